@@ rtl/ldfp_pkg.sv @@
// ----------------------------------------------------------------------------
// ldfp_pkg
// Shared widths, constants and types for the nine-byte range frame parser.
// ----------------------------------------------------------------------------
package ldfp_pkg;

    localparam int BYTE_W    = 8;
    localparam int DIST_W    = 16;
    localparam int POS_W     = 4;

    localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'h59;

    // Frame layout: two headers, distance low/high, payload, checksum last
    localparam logic [POS_W-1:0] POS_HUNT  = 4'd0;
    localparam logic [POS_W-1:0] POS_HDR2  = 4'd1;
    localparam logic [POS_W-1:0] POS_DLO   = 4'd2;
    localparam logic [POS_W-1:0] POS_DHI   = 4'd3;
    localparam logic [POS_W-1:0] POS_PAY_LO = 4'd4;
    localparam logic [POS_W-1:0] POS_PAY_HI = 4'd7;
    localparam logic [POS_W-1:0] POS_CHK   = 4'd8;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              frame_ok;
    } result_t;

endpackage

@@ rtl/ldfp_byte_if.sv @@
// ----------------------------------------------------------------------------
// ldfp_byte_if
// Valid/ready channel carrying one received byte from the sensor link.
// ----------------------------------------------------------------------------
interface ldfp_byte_if;

    logic                         valid;
    logic                         ready;
    logic [ldfp_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);

endinterface

@@ rtl/ldfp_result_if.sv @@
// ----------------------------------------------------------------------------
// ldfp_result_if
// Valid/ready channel carrying one parsed frame result.
// ----------------------------------------------------------------------------
interface ldfp_result_if;

    logic                         valid;
    logic                         ready;
    logic [ldfp_pkg::DIST_W-1:0]  distance;
    logic                         frame_ok;

    modport source (output valid, output distance, output frame_ok, input ready);
    modport sink   (input valid, input distance, input frame_ok, output ready);

endinterface

@@ rtl/lidar_distance_frame_parser.sv @@
// ----------------------------------------------------------------------------
// lidar_distance_frame_parser
// Nine-byte range-sensor frame parser with an 8-bit sum checksum.
// ----------------------------------------------------------------------------
// Usage:
//   rx  : one received link byte per item (valid/ready).
//   res : one item per completed frame: distance (bytes 2,3 little-endian)
//         and frame_ok (low byte of the sum of bytes 0..7 equals byte 8).
//   Bytes are tracked after two 0x59 headers; non-header bytes while
//   hunting and a wrong second header give no result item.
// Order: a byte is held in the input register, then the parser updates its
//   state and loads the result register, so a frame result item is valid
//   once its checksum byte has passed through both registers.
// Throughput: one byte per cycle while the result register has room, set by
//   the state update (running sum add plus compare) between the two registers.
// Reset: clears both registers' valid flags and returns the parser to the
//   header hunt with a zero sum.
// Stall: while a result waits in the result register, the parser holds
//   and the input register fills; rx.ready falls once both are full and
//   rises again in the cycle the result item is taken.
// ----------------------------------------------------------------------------
module lidar_distance_frame_parser
(
    input  logic           clk,
    input  logic           rst_n,
    ldfp_byte_if.sink      rx,
    ldfp_result_if.source  res
);

    logic                         byte_valid;
    logic [ldfp_pkg::BYTE_W-1:0]  byte_data;
    logic                         take;
    logic                         out_free;
    logic                         core_valid;
    ldfp_pkg::result_t            core_data;
    ldfp_pkg::result_t            out_data;

    ldfp_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (rx.valid),
        .in_ready   (rx.ready),
        .in_byte    (rx.rx_byte),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .take       (take)
    );

    ldfp_parser_core u_parser_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .out_free   (out_free),
        .take       (take),
        .res_valid  (core_valid),
        .res_data   (core_data)
    );

    ldfp_out_stage u_out_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_valid  (core_valid),
        .res_data   (core_data),
        .out_free   (out_free),
        .out_valid  (res.valid),
        .out_ready  (res.ready),
        .out_data   (out_data)
    );

    // Unpack the held result onto the channel
    assign res.distance = out_data.distance;
    assign res.frame_ok = out_data.frame_ok;

endmodule

@@ rtl/ldfp_in_stage.sv @@
// ----------------------------------------------------------------------------
// ldfp_in_stage
// Input register: holds one received byte until the parser core takes it.
// ----------------------------------------------------------------------------
module ldfp_in_stage
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ldfp_pkg::BYTE_W-1:0]  in_byte,
    output logic                         byte_valid,
    output logic [ldfp_pkg::BYTE_W-1:0]  byte_data,
    input  logic                         take
);

    logic                         vld_reg;
    logic                         vld_next;
    logic [ldfp_pkg::BYTE_W-1:0]  byte_reg;

    // Accept a new item when empty or when the held one leaves this cycle
    assign in_ready   = !vld_reg || take;
    assign byte_valid = vld_reg;
    assign byte_data  = byte_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (in_ready)
        begin
            vld_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Load payload with each accepted item
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= in_byte;
        end
    end

endmodule

@@ rtl/ldfp_parser_core.sv @@
// ----------------------------------------------------------------------------
// ldfp_parser_core
// Frame tracker: header hunt, running sum, distance capture, checksum check.
// ----------------------------------------------------------------------------
module ldfp_parser_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         byte_valid,
    input  logic [ldfp_pkg::BYTE_W-1:0]  byte_data,
    input  logic                         out_free,
    output logic                         take,
    output logic                         res_valid,
    output ldfp_pkg::result_t            res_data
);

    logic [ldfp_pkg::POS_W-1:0]   pos_reg;
    logic [ldfp_pkg::POS_W-1:0]   pos_next;
    logic [ldfp_pkg::BYTE_W-1:0]  sum_reg;
    logic [ldfp_pkg::BYTE_W-1:0]  sum_next;
    logic [ldfp_pkg::BYTE_W-1:0]  dlo_reg;
    logic [ldfp_pkg::BYTE_W-1:0]  dlo_next;
    logic [ldfp_pkg::BYTE_W-1:0]  dhi_reg;
    logic [ldfp_pkg::BYTE_W-1:0]  dhi_next;
    logic [ldfp_pkg::BYTE_W-1:0]  sum_add;
    logic                         is_header;

    // Advance only when the result register has room
    assign take      = byte_valid && out_free;
    assign sum_add   = sum_reg + byte_data;
    assign is_header = (byte_data == ldfp_pkg::HEADER_BYTE);

    always_comb
    begin
        pos_next           = pos_reg;
        sum_next           = sum_reg;
        dlo_next           = dlo_reg;
        dhi_next           = dhi_reg;
        res_valid          = 1'b0;
        res_data.distance  = {dhi_reg, dlo_reg};
        res_data.frame_ok  = (sum_reg == byte_data);
        if (take)
        begin
            unique case (pos_reg) inside
                ldfp_pkg::POS_HUNT:
                begin
                    // Start a frame on the first header, drop anything else
                    if (is_header)
                    begin
                        sum_next = byte_data;
                        pos_next = ldfp_pkg::POS_HDR2;
                    end
                end
                ldfp_pkg::POS_HDR2:
                begin
                    // Wrong second header restarts the hunt
                    if (is_header)
                    begin
                        sum_next = sum_add;
                        pos_next = ldfp_pkg::POS_DLO;
                    end
                    else
                    begin
                        pos_next = ldfp_pkg::POS_HUNT;
                    end
                end
                ldfp_pkg::POS_DLO:
                begin
                    dlo_next = byte_data;
                    sum_next = sum_add;
                    pos_next = pos_reg + 1'b1;
                end
                ldfp_pkg::POS_DHI:
                begin
                    dhi_next = byte_data;
                    sum_next = sum_add;
                    pos_next = pos_reg + 1'b1;
                end
                [ldfp_pkg::POS_PAY_LO:ldfp_pkg::POS_PAY_HI]:
                begin
                    sum_next = sum_add;
                    pos_next = pos_reg + 1'b1;
                end
                default:
                begin
                    // Checksum byte: emit the frame and return to the hunt
                    res_valid = 1'b1;
                    sum_next  = '0;
                    pos_next  = ldfp_pkg::POS_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= ldfp_pkg::POS_HUNT;
            sum_reg <= '0;
            dlo_reg <= '0;
            dhi_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
            dlo_reg <= dlo_next;
            dhi_reg <= dhi_next;
        end
    end

endmodule

@@ rtl/ldfp_out_stage.sv @@
// ----------------------------------------------------------------------------
// ldfp_out_stage
// Result register: holds one frame result until the receiver takes it.
// ----------------------------------------------------------------------------
module ldfp_out_stage
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  res_valid,
    input  ldfp_pkg::result_t     res_data,
    output logic                  out_free,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ldfp_pkg::result_t     out_data
);

    logic               vld_reg;
    logic               vld_next;
    ldfp_pkg::result_t  data_reg;

    // Free when empty or when the held item is taken this cycle
    assign out_free  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (out_free)
        begin
            vld_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Load payload with each new result
    always_ff @(posedge clk)
    begin
        if (out_free && res_valid)
        begin
            data_reg <= res_data;
        end
    end

endmodule
